>>> sv/imu_complementary_attitude_filter_core_defines.svh
// ----------------------------------------------------------------------------
// IMU attitude filter assertion macros
// Shared assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_CORE_DEFINES_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMU_CAF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imu_caf same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IMU_CAF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imu_caf next-cycle check failed");

`endif

>>> sv/imu_caf_pkg.sv
// ----------------------------------------------------------------------------
// IMU attitude filter package
// Types, constants and helper functions shared by the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_caf_pkg;

  // Default parameter values.
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 6;

  // Port widths.
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_ANG_W  = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;
  localparam int BLEND_W    = 17;
  localparam int PERIOD_W   = 25;
  localparam int ACCEL_W    = 17;
  localparam int RATE_W     = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'd1;

  localparam logic [BLEND_W-1:0]  BLEND_RESET  = 17'd64880;
  localparam logic [BLEND_W-1:0]  BLEND_ONE    = 17'd65536;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 25'd67109;

  // Datapath widths.
  localparam int ACC_W    = 24;
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 26;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int CRD_W    = 32;
  localparam int SQ_W     = 34;
  localparam int SQRT_IN_W  = 50;
  localparam int SQRT_OUT_W = 25;
  localparam int SQRT_CNT_W = 5;
  localparam int TAB_IDX_W  = 5;
  localparam int TAB_VAL_W  = 22;

  typedef logic signed [63:0]      wide_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;
  typedef logic signed [CRD_W-1:0]   crd_t;

  // CORDIC constants, angles in Q.16 degrees.
  localparam crd_t INV_GAIN_Q30 = 32'sd652032874;
  localparam crd_t FULL_TURN    = 32'sd23592960;
  localparam crd_t HALF_TURN_16 = 32'sd11796480;
  localparam crd_t QUARTER_16   = 32'sd5898240;

  localparam wide_t ACC_MAX = 64'sd8388607;
  localparam wide_t ACC_MIN = -64'sd8388608;

  // Command from the sequencer to the CORDIC unit.
  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_cmd_t;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z,
    ST_RT1_GO, ST_RT1_WAIT, ST_RT2_GO, ST_RT2_WAIT,
    ST_AT1_GO, ST_AT1_WAIT, ST_AT2_GO, ST_AT2_WAIT, ST_TILT,
    ST_SEED, ST_GX, ST_GY, ST_GZ, ST_GZ_USE, ST_REDUCE, ST_FOLD,
    ST_SIN_GO, ST_SIN_WAIT, ST_CR1, ST_CR1_USE, ST_CR2, ST_CR2_USE,
    ST_WRAP, ST_BL1, ST_BL2, ST_BL3, ST_BL4, ST_BL5, ST_DONE
  } state_t;

  // atan(2^-i) in Q.16 degrees.
  function automatic logic [TAB_VAL_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
    logic [TAB_VAL_W-1:0] t;
    case (idx)
      5'd0:  t = 22'd2949120;
      5'd1:  t = 22'd1740967;
      5'd2:  t = 22'd919879;
      5'd3:  t = 22'd466945;
      5'd4:  t = 22'd234379;
      5'd5:  t = 22'd117304;
      5'd6:  t = 22'd58666;
      5'd7:  t = 22'd29335;
      5'd8:  t = 22'd14668;
      5'd9:  t = 22'd7334;
      5'd10: t = 22'd3667;
      5'd11: t = 22'd1833;
      5'd12: t = 22'd917;
      5'd13: t = 22'd458;
      5'd14: t = 22'd229;
      5'd15: t = 22'd115;
      5'd16: t = 22'd57;
      5'd17: t = 22'd29;
      5'd18: t = 22'd14;
      5'd19: t = 22'd7;
      5'd20: t = 22'd4;
      5'd21: t = 22'd2;
      5'd22: t = 22'd1;
      default: t = 22'd0;
    endcase
    return t;
  endfunction

  // Round half up, then drop s fraction bits (s >= 1).
  function automatic wide_t rnd_sh(input wide_t v, input int s);
    wide_t half;
    half = 64'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  // Saturate to the accumulator range.
  function automatic acc_t sat_acc(input wide_t v);
    wide_t w;
    w = v;
    if (w > ACC_MAX) w = ACC_MAX;
    if (w < ACC_MIN) w = ACC_MIN;
    return w[ACC_W-1:0];
  endfunction

  // Wrap once into -h..h, then saturate.
  function automatic acc_t wrap_acc(input acc_t v, input wide_t h);
    wide_t w;
    w = 64'(v);
    if (w > h) w = w - 2 * h;
    else if (w < -h) w = w + 2 * h;
    return sat_acc(w);
  endfunction

  // Clamp to -h..h and keep the output field bits.
  function automatic logic [OUT_ANG_W-1:0] out_angle(input acc_t v, input wide_t h);
    wide_t w;
    w = 64'(v);
    if (w > h) w = h;
    if (w < -h) w = -h;
    return w[OUT_ANG_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/imu_complementary_attitude_filter_core.sv
// An invalid sample goes straight to the done state and its result is registered.
// A valid sample's run time is set by the two 25-step square roots, the three
// CORDIC passes, the shared multiplier and the angle reduction loop.
// Input is not ready while a sample runs, so a new sample waits for the last result.
// Reset (synchronous, rst high): angles and tilts clear, first sample pending.
// ----------------------------------------------------------------------------
// IMU complementary attitude filter core
// Sequencer around a shared multiplier, square root and CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_attitude_filter_core import imu_caf_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // sensor_ok
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // roll_angle, pitch_angle, yaw_angle, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // updated
  output logic                       m_axis_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TW = ANGLE_FRAC_BITS + 10;
  localparam int DS = 16 - ANGLE_FRAC_BITS;
  localparam int GS = 28 - ANGLE_FRAC_BITS;
  localparam wide_t HALF_TURN = wide_t'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [TW-1:0] HALF_T = TW'(180 << ANGLE_FRAC_BITS);

  state_t state, state_next;

  logic [BLEND_W-1:0]  blend_weight;
  logic [PERIOD_W-1:0] sample_period;

  logic                       ok;
  logic signed [ACCEL_W-1:0]  ax, ay, az;
  logic signed [RATE_W-1:0]   gx, gy, gz;
  logic signed [TW-1:0]       tilt_x, tilt_y;
  acc_t                       roll, pitch, yaw;
  logic                       first_sample;
  logic [SQ_W-1:0]            sqx, sqy, sqz;
  logic [SQRT_OUT_W-1:0]      hx, hy;
  wide_t                      tmp;
  crd_t                       v;
  crd_t                       s;

  logic        accept;
  logic        in_ok;
  logic        in_nonzero;
  wide_t       mp;
  mul_a_t      mul_a;
  mul_b_t      mul_b;
  mul_p_t      mul_p;
  logic [BLEND_W-1:0] aw, bw;
  logic        sqrt_start, sqrt_done;
  logic [SQRT_IN_W-1:0]  sqrt_in;
  logic [SQRT_OUT_W-1:0] sqrt_root;
  cordic_cmd_t crd_cmd;
  crd_t        crd_x0, crd_y0, crd_z0, crd_y, crd_z;
  logic        crd_done;
  crd_t        ax_sc, ay_sc, zsel;
  crd_t        vfold;
  logic        out_free;

  assign in_ok      = s_axis_tuser;
  assign in_nonzero = |s_axis_tdata[3*ACCEL_W-1:0];
  assign accept     = s_axis_tvalid & s_axis_tready;
  assign mp         = 64'(mul_p);
  assign aw         = (blend_weight > BLEND_ONE) ? BLEND_ONE : blend_weight;
  assign bw         = BLEND_ONE - aw;
  assign ax_sc      = CRD_W'(ax) <<< 8;
  assign ay_sc      = CRD_W'(ay) <<< 8;
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  // Shared units.
  imu_caf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  imu_caf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .root     (sqrt_root),
    .done     (sqrt_done)
  );

  imu_caf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .cmd   (crd_cmd),
    .x0    (crd_x0),
    .y0    (crd_y0),
    .z0    (crd_z0),
    .y_out (crd_y),
    .z_out (crd_z),
    .done  (crd_done)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!in_ok) state_next = ST_DONE;
          else if (in_nonzero) state_next = ST_SQ_X;
          else if (first_sample) state_next = ST_SEED;
          else state_next = ST_GX;
        end
      end
      ST_SQ_X:     state_next = ST_SQ_Y;
      ST_SQ_Y:     state_next = ST_SQ_Z;
      ST_SQ_Z:     state_next = ST_RT1_GO;
      ST_RT1_GO:   state_next = ST_RT1_WAIT;
      ST_RT1_WAIT: if (sqrt_done) state_next = ST_RT2_GO;
      ST_RT2_GO:   state_next = ST_RT2_WAIT;
      ST_RT2_WAIT: if (sqrt_done) state_next = ST_AT1_GO;
      ST_AT1_GO:   state_next = ST_AT1_WAIT;
      ST_AT1_WAIT: if (crd_done) state_next = ST_AT2_GO;
      ST_AT2_GO:   state_next = ST_AT2_WAIT;
      ST_AT2_WAIT: if (crd_done) state_next = ST_TILT;
      ST_TILT:     state_next = first_sample ? ST_SEED : ST_GX;
      ST_SEED:     state_next = ST_DONE;
      ST_GX:       state_next = ST_GY;
      ST_GY:       state_next = ST_GZ;
      ST_GZ:       state_next = ST_GZ_USE;
      ST_GZ_USE:   state_next = ST_REDUCE;
      ST_REDUCE:   if (v >= 0 && v < FULL_TURN) state_next = ST_FOLD;
      ST_FOLD:     state_next = ST_SIN_GO;
      ST_SIN_GO:   state_next = ST_SIN_WAIT;
      ST_SIN_WAIT: if (crd_done) state_next = ST_CR1;
      ST_CR1:      state_next = ST_CR1_USE;
      ST_CR1_USE:  state_next = ST_CR2;
      ST_CR2:      state_next = ST_CR2_USE;
      ST_CR2_USE:  state_next = ST_WRAP;
      ST_WRAP:     state_next = ST_BL1;
      ST_BL1:      state_next = ST_BL2;
      ST_BL2:      state_next = ST_BL3;
      ST_BL3:      state_next = ST_BL4;
      ST_BL4:      state_next = ST_BL5;
      ST_BL5:      state_next = ST_DONE;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs: multiplier operands and unit requests.
  always_comb begin
    s_axis_tready    = (state == ST_IDLE);
    mul_a            = '0;
    mul_b            = '0;
    sqrt_start       = 1'b0;
    sqrt_in          = '0;
    crd_cmd.start    = 1'b0;
    crd_cmd.vec_mode = 1'b1;
    crd_x0           = '0;
    crd_y0           = '0;
    crd_z0           = '0;
    case (state)
      ST_SQ_X: begin mul_a = MUL_A_W'(ax); mul_b = MUL_B_W'(ax); end
      ST_SQ_Y: begin mul_a = MUL_A_W'(ay); mul_b = MUL_B_W'(ay); end
      ST_SQ_Z: begin mul_a = MUL_A_W'(az); mul_b = MUL_B_W'(az); end
      ST_RT1_GO: begin
        sqrt_start = 1'b1;
        sqrt_in    = {SQ_W'(sqy + mul_p[SQ_W-1:0]), 16'b0};
      end
      ST_RT2_GO: begin
        sqrt_start = 1'b1;
        sqrt_in    = {SQ_W'(sqx + sqz), 16'b0};
      end
      ST_AT1_GO: begin
        crd_cmd.start = 1'b1;
        crd_x0        = CRD_W'(hx);
        crd_y0        = (ax_sc < 0) ? -ax_sc : ax_sc;
      end
      ST_AT2_GO: begin
        crd_cmd.start = 1'b1;
        crd_x0        = CRD_W'(hy);
        crd_y0        = (ay_sc < 0) ? -ay_sc : ay_sc;
      end
      ST_SIN_GO: begin
        crd_cmd.start    = 1'b1;
        crd_cmd.vec_mode = 1'b0;
        crd_x0           = INV_GAIN_Q30;
        crd_z0           = v;
      end
      ST_GX:  begin mul_a = MUL_A_W'(gx); mul_b = MUL_B_W'({1'b0, sample_period}); end
      ST_GY:  begin mul_a = MUL_A_W'(gy); mul_b = MUL_B_W'({1'b0, sample_period}); end
      ST_GZ:  begin mul_a = MUL_A_W'(gz); mul_b = MUL_B_W'({1'b0, sample_period}); end
      ST_CR1: begin mul_a = s; mul_b = MUL_B_W'(pitch); end
      ST_CR2: begin mul_a = s; mul_b = MUL_B_W'(roll); end
      ST_BL1: begin mul_a = MUL_A_W'(roll);   mul_b = MUL_B_W'({1'b0, aw}); end
      ST_BL2: begin mul_a = MUL_A_W'(tilt_y); mul_b = MUL_B_W'({1'b0, bw}); end
      ST_BL3: begin mul_a = MUL_A_W'(pitch);  mul_b = MUL_B_W'({1'b0, aw}); end
      ST_BL4: begin mul_a = MUL_A_W'(tilt_x); mul_b = MUL_B_W'({1'b0, bw}); end
      default: begin end
    endcase
  end

  // Signed arctangent from the unit's unsigned result.
  always_comb begin
    zsel = crd_z;
    if (state == ST_AT1_WAIT) begin
      if (ax == 0) zsel = '0;
      else if (ax < 0) zsel = -crd_z;
    end else begin
      if (ay == 0) zsel = '0;
      else if (ay < 0) zsel = -crd_z;
    end
  end

  // Fold the reduced sine argument into -90..90 degrees.
  always_comb begin
    vfold = (v >= HALF_TURN_16) ? v - FULL_TURN : v;
    if (vfold > QUARTER_16) vfold = HALF_TURN_16 - vfold;
    else if (vfold < -QUARTER_16) vfold = -HALF_TURN_16 - vfold;
  end

  // Sequencer state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      blend_weight  <= BLEND_RESET;
      sample_period <= PERIOD_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_BLEND_WEIGHT:  blend_weight  <= cfg_data[BLEND_W-1:0];
          REG_SAMPLE_PERIOD: sample_period <= cfg_data[PERIOD_W-1:0];
          default: begin end
        endcase
      end
    end
  end

  // Attitude state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_x       <= '0;
      tilt_y       <= '0;
      roll         <= '0;
      pitch        <= '0;
      yaw          <= '0;
      first_sample <= 1'b1;
    end else begin
      case (state)
        ST_AT1_WAIT: if (crd_done) tilt_x <= TW'(rnd_sh(-64'(zsel), DS));
        ST_AT2_WAIT: if (crd_done) tilt_y <= TW'(rnd_sh(64'(zsel), DS));
        ST_TILT: begin
          if (az < 0) begin
            tilt_x <= (tilt_x > 0) ? HALF_T - tilt_x : -HALF_T - tilt_x;
            tilt_y <= (tilt_y > 0) ? HALF_T - tilt_y : -HALF_T - tilt_y;
          end
        end
        ST_SEED: begin
          roll         <= ACC_W'(tilt_x);
          pitch        <= ACC_W'(tilt_y);
          yaw          <= '0;
          first_sample <= 1'b0;
        end
        ST_GY:     roll  <= sat_acc(64'(roll) + rnd_sh(mp, GS));
        ST_GZ:     pitch <= sat_acc(64'(pitch) + rnd_sh(mp, GS));
        ST_GZ_USE: yaw   <= sat_acc(64'(yaw) + rnd_sh(mp, GS));
        ST_CR1_USE: roll  <= sat_acc(64'(roll) + rnd_sh(mp, 30));
        ST_CR2_USE: pitch <= sat_acc(64'(pitch) - rnd_sh(mp, 30));
        ST_WRAP: begin
          roll  <= wrap_acc(roll, HALF_TURN);
          pitch <= wrap_acc(pitch, HALF_TURN);
          yaw   <= wrap_acc(yaw, HALF_TURN);
        end
        ST_BL3: roll  <= sat_acc(rnd_sh(tmp + mp, 16));
        ST_BL5: pitch <= sat_acc(rnd_sh(tmp + mp, 16));
        default: begin end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ok <= in_ok;
      ax <= s_axis_tdata[ACCEL_W-1:0];
      ay <= s_axis_tdata[2*ACCEL_W-1:ACCEL_W];
      az <= s_axis_tdata[3*ACCEL_W-1:2*ACCEL_W];
      gx <= s_axis_tdata[3*ACCEL_W+RATE_W-1:3*ACCEL_W];
      gy <= s_axis_tdata[3*ACCEL_W+2*RATE_W-1:3*ACCEL_W+RATE_W];
      gz <= s_axis_tdata[3*ACCEL_W+3*RATE_W-1:3*ACCEL_W+2*RATE_W];
    end
    case (state)
      ST_SQ_Y:     sqx <= mul_p[SQ_W-1:0];
      ST_SQ_Z:     sqy <= mul_p[SQ_W-1:0];
      ST_RT1_GO:   sqz <= mul_p[SQ_W-1:0];
      ST_RT1_WAIT: if (sqrt_done) hx <= sqrt_root;
      ST_RT2_WAIT: if (sqrt_done) hy <= sqrt_root;
      ST_GZ_USE:   v <= CRD_W'(rnd_sh(mp, 12));
      ST_REDUCE: begin
        if (v < 0) v <= v + FULL_TURN;
        else if (v >= FULL_TURN) v <= v - FULL_TURN;
      end
      ST_FOLD:     v <= vfold;
      ST_SIN_WAIT: if (crd_done) s <= crd_y;
      ST_BL2:      tmp <= mp;
      ST_BL4:      tmp <= mp;
      default: begin end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {3'b000, out_angle(yaw, HALF_TURN), out_angle(pitch, HALF_TURN),
                       out_angle(roll, HALF_TURN)};
      m_axis_tuser <= ok;
    end
  end

endmodule

`default_nettype wire

>>> sv/imu_caf_mul.sv
// ----------------------------------------------------------------------------
// IMU attitude filter shared multiplier
// One signed multiplier with a registered product, time-shared by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_caf_mul import imu_caf_pkg::*; (
  input  wire logic   clk,
  input  wire mul_a_t a,
  input  wire mul_b_t b,
  output mul_p_t      p
);

  // Product is registered and appears in the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

>>> sv/imu_caf_sqrt.sv
// ----------------------------------------------------------------------------
// IMU attitude filter integer square root
// Bit-pair restoring square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_caf_sqrt import imu_caf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [SQRT_IN_W-1:0]  radicand,
  output logic [SQRT_OUT_W-1:0]      root,
  output logic                       done
);

  localparam logic [SQRT_CNT_W-1:0] LAST_K = SQRT_CNT_W'(SQRT_OUT_W - 1);

  logic [SQRT_IN_W-1:0]  rem;
  logic [SQRT_IN_W-1:0]  r;
  logic [SQRT_CNT_W-1:0] k;
  logic                  run;
  logic [SQRT_IN_W-1:0]  bitv;
  logic [SQRT_IN_W-1:0]  trial;

  // Current bit pair and trial subtrahend.
  always_comb begin
    bitv  = SQRT_IN_W'(1) << {k, 1'b0};
    trial = r + bitv;
  end

  // Control: run for one step per result bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        k   <= LAST_K;
      end else if (run) begin
        if (k == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  // Datapath: conditional subtract and shift.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= radicand;
      r   <= '0;
    end else if (run) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        r   <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
    end
  end

  assign root = r[SQRT_OUT_W-1:0];

endmodule

`default_nettype wire

>>> sv/imu_caf_cordic.sv
// ----------------------------------------------------------------------------
// IMU attitude filter CORDIC unit
// Iterative CORDIC in vectoring mode (arctangent) or rotation mode (sine).
// ----------------------------------------------------------------------------
`default_nettype none

module imu_caf_cordic import imu_caf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cordic_cmd_t cmd,
  input  wire crd_t        x0,
  input  wire crd_t        y0,
  input  wire crd_t        z0,
  output crd_t             y_out,
  output crd_t             z_out,
  output logic             done
);

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CW-1:0] LAST_I = CW'(CORDIC_STEPS - 1);

  crd_t          x, y, z;
  logic [CW-1:0] i;
  logic          run;
  logic          vmode;
  crd_t          dx, dy, tab;
  logic          neg;

  // One micro-rotation.
  always_comb begin
    dx  = y >>> i;
    dy  = x >>> i;
    tab = CRD_W'(atan_q16(TAB_IDX_W'(i)));
    neg = vmode ? (y > 0) : (z < 0);
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        run <= 1'b1;
        i   <= '0;
      end else if (run) begin
        if (i == LAST_I) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          i <= i + 1'b1;
        end
      end
    end
  end

  // Vector registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x     <= x0;
      y     <= y0;
      z     <= z0;
      vmode <= cmd.vec_mode;
    end else if (run) begin
      if (neg) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + tab;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - tab;
      end
    end
  end

  assign y_out = y;
  assign z_out = z;

endmodule

`default_nettype wire

>>> sv/imu_caf_checker.sv
// ----------------------------------------------------------------------------
// IMU attitude filter port checker
// Watches the top-level ports over time and is bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_complementary_attitude_filter_core_defines.svh"

module imu_caf_checker import imu_caf_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser
);

  // A stalled result holds.
  `IMU_CAF_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // The block is busy right after taking a request.
  `IMU_CAF_ASSERT_NXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready,
    !s_axis_tready)

  // A new result only appears while the input side was busy.
  `IMU_CAF_ASSERT_IMP(a_result_from_work, clk, rst, $rose(m_axis_tvalid),
    !$past(s_axis_tready))

  // Roll stays within plus or minus 180 degrees.
  `IMU_CAF_ASSERT_IMP(a_roll_range, clk, rst, m_axis_tvalid,
    ($signed(m_axis_tdata[14:0]) <= 15'sd11520) &&
    ($signed(m_axis_tdata[14:0]) >= -15'sd11520))

endmodule

bind imu_complementary_attitude_filter_core imu_caf_checker u_imu_caf_checker (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU complementary attitude filter core testbench
// Drives IMU samples through the stream port, predicts the attitude with an
// independent fixed-point model and checks every result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import imu_caf_pkg::*;

  localparam int AFB = ANGLE_FRAC_BITS_DEF;
  localparam longint HALF_DEG = 180 <<< AFB;
  localparam int N_RANDOM = 1850;
  localparam int WATCHDOG_LIMIT = 20000;

  // One attitude sample and the result it gives.
  typedef struct {
    logic               ok;
    logic signed [16:0] ax, ay, az;
    logic signed [15:0] gx, gy, gz;
  } imu_sample_t;

  typedef struct packed {
    logic [14:0] roll, pitch, yaw;
    logic        updated;
  } attitude_t;

  // Directed stimulus row: sample plus an optional typed-in expectation.
  typedef struct {
    imu_sample_t smp;
    logic        fixed;
    attitude_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  imu_complementary_attitude_filter_core i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state and configuration.
  longint weight_q16, period_q24;
  longint held_tx, held_ty, att_roll, att_pitch, att_yaw;
  bit     awaiting_seed;

  attitude_t pending_att[$];
  int  n_errors = 0, n_results = 0, n_valid = 0, n_invalid = 0, n_flip = 0;
  bit  rx_quiet = 1'b0, tx_quiet = 1'b0;
  int  idle_cycles = 0;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
      1, 0};
    return t[i];
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Vectoring CORDIC, angle in Q.16 degrees.
  function automatic longint vec_angle(longint x, longint y);
    longint z = 0, m, dx, dy;
    m = (y < 0) ? -y : y;
    if (y == 0) return 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = shr(m, i);
      dy = shr(x, i);
      if (m > 0) begin
        x += dx; m -= dy; z += atan_entry(i);
      end else begin
        x -= dx; m += dy; z -= atan_entry(i);
      end
    end
    return (y < 0) ? -z : z;
  endfunction

  // Rotating CORDIC sine of a Q.16 degree angle, Q.30 result.
  function automatic longint sine_q30(longint v);
    longint full = 360 <<< 16, half = 180 <<< 16, quarter = 90 <<< 16;
    longint x = 652032874, y = 0, dx, dy;
    v = v % full;
    if (v < 0) v += full;
    if (v >= half) v -= full;
    if (v > quarter) v = half - v;
    else if (v < -quarter) v = -half - v;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (v >= 0) begin
        x -= dx; y += dy; v -= atan_entry(i);
      end else begin
        x += dx; y -= dy; v += atan_entry(i);
      end
    end
    return y;
  endfunction

  function automatic longint mirror(longint t);
    return (t > 0) ? HALF_DEG - t : -HALF_DEG - t;
  endfunction

  function automatic longint wrap1(longint v);
    if (v > HALF_DEG) v -= 2 * HALF_DEG;
    else if (v < -HALF_DEG) v += 2 * HALF_DEG;
    return clamp24(v);
  endfunction

  function automatic logic [14:0] clip_out(longint v);
    if (v > HALF_DEG) v = HALF_DEG;
    if (v < -HALF_DEG) v = -HALF_DEG;
    return v[14:0];
  endfunction

  task automatic attitude_reset();
    weight_q16 = BLEND_RESET; period_q24 = PERIOD_RESET;
    held_tx = 0; held_ty = 0; att_roll = 0; att_pitch = 0; att_yaw = 0;
    awaiting_seed = 1'b1;
  endtask

  // Advance the predicted attitude by one accepted sample.
  task automatic predict_attitude(input imu_sample_t s, output attitude_t r);
    longint ax, ay, az, gx, gy, gz, hx, hy, w, sn;
    ax = s.ax; ay = s.ay; az = s.az; gx = s.gx; gy = s.gy; gz = s.gz;
    if (s.ok) begin
      if (ax != 0 || ay != 0 || az != 0) begin
        hx = int_sqrt(longint'(ay * ay + az * az) << 16);
        hy = int_sqrt(longint'(ax * ax + az * az) << 16);
        held_tx = round_sh(-vec_angle(hx, ax * 256), 16 - AFB);
        held_ty = round_sh(vec_angle(hy, ay * 256), 16 - AFB);
        if (az < 0) begin
          held_tx = mirror(held_tx);
          held_ty = mirror(held_ty);
        end
      end
      if (awaiting_seed) begin
        att_roll = clamp24(held_tx); att_pitch = clamp24(held_ty); att_yaw = 0;
        awaiting_seed = 1'b0;
      end else begin
        w = (weight_q16 > 65536) ? 65536 : weight_q16;
        att_roll = clamp24(att_roll + round_sh(gx * period_q24, 28 - AFB));
        att_pitch = clamp24(att_pitch + round_sh(gy * period_q24, 28 - AFB));
        att_yaw = clamp24(att_yaw + round_sh(gz * period_q24, 28 - AFB));
        sn = sine_q30(round_sh(gz * period_q24, 12));
        att_roll = clamp24(att_roll + round_sh(sn * att_pitch, 30));
        att_pitch = clamp24(att_pitch - round_sh(sn * att_roll, 30));
        att_roll = wrap1(att_roll);
        att_pitch = wrap1(att_pitch);
        att_yaw = wrap1(att_yaw);
        att_roll = clamp24(round_sh(w * att_roll + (65536 - w) * held_ty, 16));
        att_pitch = clamp24(round_sh(w * att_pitch + (65536 - w) * held_tx, 16));
      end
    end
    r.roll = clip_out(att_roll);
    r.pitch = clip_out(att_pitch);
    r.yaw = clip_out(att_yaw);
    r.updated = s.ok;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Output side: random stall and in-order comparison.
  always @(posedge clk) begin
    attitude_t w;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (pending_att.size() == 0) begin
          report_mismatch("unexpected result, queue depth", 0, 1);
        end else begin
          w = pending_att.pop_front();
          if (m_axis_tdata[14:0] !== w.roll)
            report_mismatch("roll", $signed(m_axis_tdata[14:0]), $signed(w.roll));
          if (m_axis_tdata[29:15] !== w.pitch)
            report_mismatch("pitch", $signed(m_axis_tdata[29:15]), $signed(w.pitch));
          if (m_axis_tdata[44:30] !== w.yaw)
            report_mismatch("yaw", $signed(m_axis_tdata[44:30]), $signed(w.yaw));
          if (m_axis_tdata[47:45] !== 3'b000)
            report_mismatch("fill bits", m_axis_tdata[47:45], 0);
          if (m_axis_tuser !== w.updated)
            report_mismatch("updated", m_axis_tuser, w.updated);
        end
      end
      m_axis_tready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 8);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending_att.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Send one sample and wait for its acceptance; valid stays up until the
  // next request or an idle cycle replaces it.
  task automatic send_sample(input imu_sample_t s);
    attitude_t r;
    while (!tx_quiet && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata <= {8'd0, s.gz, s.gy, s.gx, s.az, s.ay, s.ax};
    s_axis_tuser <= s.ok;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_attitude(s, r);
    pending_att.push_back(r);
    if (s.ok) n_valid++; else n_invalid++;
    if (s.ok && s.az < 0) n_flip++;
  endtask

  // Wait for every result, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_att.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLEND_WEIGHT) weight_q16 = val & 64'h1FFFF;
    else period_q24 = val & 64'h1FFFFFF;
  endtask

  function automatic imu_sample_t mk(logic ok, int ax, int ay, int az,
                                     int gx, int gy, int gz);
    imu_sample_t s;
    s.ok = ok; s.ax = 17'(ax); s.ay = 17'(ay); s.az = 17'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
    return s;
  endfunction

  function automatic imu_sample_t rand_sample(bit wild);
    imu_sample_t s;
    s.ok = ($urandom_range(99) >= 6);
    if (wild) begin
      s.ax = 17'($urandom); s.ay = 17'($urandom); s.az = 17'($urandom);
      s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
    end else begin
      s.ax = 17'($signed($urandom_range(8192)) - 4096);
      s.ay = 17'($signed($urandom_range(8192)) - 4096);
      s.az = ($urandom_range(3) == 0) ? 17'(-$signed($urandom_range(4096)))
                                      : 17'($signed($urandom_range(4096)));
      s.gx = 16'($signed($urandom_range(8000)) - 4000);
      s.gy = 16'($signed($urandom_range(8000)) - 4000);
      s.gz = 16'($signed($urandom_range(8000)) - 4000);
    end
    if ($urandom_range(49) == 0) begin
      s.ax = 0; s.ay = 0; s.az = 0;
    end
    return s;
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    attitude_t r;
    attitude_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; first ones have results readable at a glance.
    row.fixed = 1'b1;
    row.smp = mk(0, 65535, -65536, 65535, 32767, -32768, 32767);
    row.res = '{roll: 0, pitch: 0, yaw: 0, updated: 0}; rows.push_back(row);
    row.smp = mk(1, 0, 0, 4096, 0, 0, 0);
    row.res = '{roll: 0, pitch: 0, yaw: 0, updated: 1}; rows.push_back(row);
    row.smp = mk(0, 0, 0, 0, 0, 0, 0);
    row.res = '{roll: 0, pitch: 0, yaw: 0, updated: 0}; rows.push_back(row);
    row.fixed = 1'b0;
    foreach (rows[i]) begin
      send_sample(rows[i].smp);
      if (rows[i].fixed && pending_att[$] != rows[i].res)
        report_mismatch("directed row expectation", i, -1);
    end
    rows.delete();
    row.smp = mk(1, 0, 0, 0, 100, -100, 50);            rows.push_back(row);
    row.smp = mk(1, 4096, 0, 0, 32767, 32767, 32767);   rows.push_back(row);
    row.smp = mk(1, -4096, 0, 0, -32768, -32768, -32768); rows.push_back(row);
    row.smp = mk(1, 0, 4096, -4096, 0, 0, 16000);       rows.push_back(row);
    row.smp = mk(1, 2000, -2000, -1, 1, -1, 0);         rows.push_back(row);
    row.smp = mk(1, 65535, 65535, 65535, 0, 0, 0);      rows.push_back(row);
    row.smp = mk(1, -65536, -65536, -65536, 0, 0, 0);   rows.push_back(row);
    row.smp = mk(1, -65536, 65535, -65536, 32767, 0, -32768); rows.push_back(row);
    row.smp = mk(0, 1, 1, 1, 1, 1, 1);                  rows.push_back(row);
    foreach (rows[i]) send_sample(rows[i].smp);
    drain();

    // Weight extremes, including one above full scale, and period extremes.
    write_reg(REG_BLEND_WEIGHT, 65536);
    write_reg(REG_SAMPLE_PERIOD, 16777216);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(i[0]));
    drain();
    write_reg(REG_BLEND_WEIGHT, 131071);
    write_reg(REG_SAMPLE_PERIOD, 1);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(1));
    drain();
    write_reg(REG_BLEND_WEIGHT, 0);
    write_reg(REG_SAMPLE_PERIOD, 33554431);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(0));
    drain();

    // Random phases with fresh settings; one phase runs with no idling.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        rx_quiet = 1'b1; tx_quiet = 1'b1;
      end else begin
        rx_quiet = 1'b0; tx_quiet = 1'b0;
      end
      write_reg(REG_BLEND_WEIGHT, (ph == 7) ? BLEND_RESET : $urandom_range(65536));
      write_reg(REG_SAMPLE_PERIOD, (ph == 7) ? PERIOD_RESET
                                             : $urandom_range(300000, 1));
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        send_sample(rand_sample($urandom_range(9) == 0));
      end
      drain();
    end

    $display("Covered %0d valid and %0d invalid samples, %0d with negative z,",
             n_valid, n_invalid, n_flip);
    $display("%0d results checked across reset, extreme and random settings.", n_results);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/imu_caf_pkg.sv
sv/imu_caf_mul.sv
sv/imu_caf_sqrt.sv
sv/imu_caf_cordic.sv
sv/imu_complementary_attitude_filter_core.sv
sv/imu_caf_checker.sv
tb/tb.sv
